// File: rtl/core/pyob_pkg.sv
// ----------------------------------------------------------------------------
// pyob_pkg
// Shared types and constants for the planar 4:2:0 overlay blender.
// ----------------------------------------------------------------------------
package pyob_pkg;

  localparam int MAX_DIM    = 4096;
  localparam int DIM_W      = $clog2(MAX_DIM + 1);
  localparam int POS_W      = $clog2(MAX_DIM);
  localparam int OFS_W      = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int ALPHA_W    = 9;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OVERLAY_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OVERLAY_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_Q8      = 3'd6;

  // plane codes
  localparam logic [1:0] PLANE_Y    = 2'd0;
  localparam logic [1:0] PLANE_U    = 2'd1;
  localparam logic [1:0] PLANE_V    = 2'd2;
  localparam logic [1:0] PLANE_NONE = 2'd3;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;

  typedef struct packed {
    logic [7:0] dest_byte;
    logic [7:0] src_byte;
  } pix_item_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic             covered;
    logic [OFS_W-1:0] src_offset;
    logic [1:0]       plane_id;
    logic             frame_end;
  } res_item_t;

  // overlay window of one plane class, bases are two's complement
  typedef struct packed {
    logic [DIM_W-1:0] x_start;
    logic [DIM_W-1:0] x_end;
    logic [DIM_W-1:0] y_start;
    logic [DIM_W-1:0] y_end;
    logic [DIM_W:0]   col_base;
    logic [DIM_W:0]   row_base;
    logic [DIM_W-1:0] stride;
  } win_t;

endpackage

// File: rtl/core/planar_yuv_overlay_blend_top.sv
// ----------------------------------------------------------------------------
// planar_yuv_overlay_blend_top
// Overlays a planar 4:2:0 source picture on a destination frame stream.
// ----------------------------------------------------------------------------
// Usage:
//   pix channel: one beat per destination byte in raster order, luma plane
//   first, then the two half-size chroma planes; each beat also carries the
//   source byte found at the src_offset reported for that position.
//   res channel: one beat per pix beat, in order, with the blended byte,
//   coverage flag, source offset, plane id and an end-of-frame mark.
//   cfg channel: register writes, always ready; write only while idle.
// A pix beat is registered in the input stage and then in the result
// register; one byte is taken every cycle unless the receiver stalls:
// the scan position update (row/column/plane wrap) is the single loop,
// the offset multiply and blend sit in the second stage.
// Reset restores the register defaults (alpha 256, all else zero), puts
// the scan at the first luma byte and empties both stages.
// When the receiver stalls, the input stage still takes one more beat
// while the result register holds; pix_ready drops once both are full.
// ----------------------------------------------------------------------------
module planar_yuv_overlay_blend_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 pix_valid,
  output logic                                 pix_ready,
  input  pyob_pkg::pix_item_t                  pix_data,
  output logic                                 res_valid,
  input  logic                                 res_ready,
  output pyob_pkg::res_item_t                  res_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pyob_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pyob_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int DIM_W = pyob_pkg::DIM_W;
  localparam int POS_W = pyob_pkg::POS_W;
  localparam int OFS_W = pyob_pkg::OFS_W;
  localparam int CW    = pyob_pkg::CFG_DATA_W;
  localparam int AW    = pyob_pkg::ALPHA_W;

  // configuration registers
  logic [CW-1:0] overlay_x;
  logic [CW-1:0] overlay_y;
  logic [CW-1:0] source_width;
  logic [CW-1:0] source_height;
  logic [CW-1:0] frame_width;
  logic [CW-1:0] frame_height;
  logic [AW-1:0] alpha_q8;

  // scan position
  logic [1:0]       plane_index;
  logic [POS_W-1:0] row_count;
  logic [POS_W-1:0] col_count;
  logic [1:0]       plane_index_next;
  logic [POS_W-1:0] row_count_next;
  logic [POS_W-1:0] col_count_next;

  // derived window
  pyob_pkg::win_t win_l;
  pyob_pkg::win_t win_c;
  pyob_pkg::win_t win_l_next;
  pyob_pkg::win_t win_c_next;
  logic           win_ok;
  logic           win_ok_next;
  logic [AW-1:0]  alpha_sat;
  logic [AW-1:0]  alpha_sat_next;

  // stage a
  logic                a_valid;
  pyob_pkg::pix_item_t a_item;
  logic [1:0]          a_plane;
  logic [POS_W-1:0]    a_row;
  logic [POS_W-1:0]    a_col;
  logic                a_last;
  logic                a_empty;

  logic advance;
  logic pix_fire;

  function automatic logic [DIM_W-1:0] sat_dim(input logic [CW-1:0] v);
    if (int'(v) > pyob_pkg::MAX_DIM) return DIM_W'(pyob_pkg::MAX_DIM);
    else return DIM_W'(v);
  endfunction

  logic [DIM_W-1:0] fw, fh, sw, sh;
  logic             ok_y, ok_c, frame_empty;

  assign fw = sat_dim(frame_width);
  assign fh = sat_dim(frame_height);
  assign sw = sat_dim(source_width);
  assign sh = sat_dim(source_height);
  assign ok_y = (fw != '0) && (fh != '0);
  assign ok_c = (fw > DIM_W'(1)) && (fh > DIM_W'(1));
  assign frame_empty = !ok_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      overlay_x     <= '0;
      overlay_y     <= '0;
      source_width  <= '0;
      source_height <= '0;
      frame_width   <= '0;
      frame_height  <= '0;
      alpha_q8      <= pyob_pkg::ALPHA_ONE;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pyob_pkg::REG_OVERLAY_X:     overlay_x     <= cfg_data;
        pyob_pkg::REG_OVERLAY_Y:     overlay_y     <= cfg_data;
        pyob_pkg::REG_SOURCE_WIDTH:  source_width  <= cfg_data;
        pyob_pkg::REG_SOURCE_HEIGHT: source_height <= cfg_data;
        pyob_pkg::REG_FRAME_WIDTH:   frame_width   <= cfg_data;
        pyob_pkg::REG_FRAME_HEIGHT:  frame_height  <= cfg_data;
        pyob_pkg::REG_ALPHA_Q8:      alpha_q8      <= cfg_data[AW-1:0];
        default: ;
      endcase
    end
  end

  // window set-up, registered once per cycle from the static registers
  logic [DIM_W:0]   xr, yr, xr_neg, yr_neg;
  logic [DIM_W-1:0] xp, yp, xo, yo;
  logic [DIM_W:0]   w_src, w_dst, h_src, h_dst, w_s, h_s;
  logic [DIM_W-1:0] w_u, h_u;

  always_comb begin
    xr = {overlay_x[CW-1], overlay_x} + (DIM_W+1)'(overlay_x[0]);
    yr = {overlay_y[CW-1], overlay_y} + (DIM_W+1)'(overlay_y[0]);
    xr_neg = -xr;
    yr_neg = -yr;
    xp = xr[DIM_W] ? '0 : xr[DIM_W-1:0];
    yp = yr[DIM_W] ? '0 : yr[DIM_W-1:0];
    xo = xr[DIM_W] ? xr_neg[DIM_W-1:0] : '0;
    yo = yr[DIM_W] ? yr_neg[DIM_W-1:0] : '0;
    w_src = {1'b0, sw} - {1'b0, xo};
    w_dst = {1'b0, fw} - {1'b0, xp};
    h_src = {1'b0, sh} - {1'b0, yo};
    h_dst = {1'b0, fh} - {1'b0, yp};
    w_s = ($signed(w_dst) < $signed(w_src)) ? w_dst : w_src;
    h_s = ($signed(h_dst) < $signed(h_src)) ? h_dst : h_src;
    w_u = w_s[DIM_W-1:0];
    h_u = h_s[DIM_W-1:0];
    win_ok_next = !(xo > sw) && !(yo > sh) && !w_s[DIM_W] && !h_s[DIM_W];

    win_l_next.x_start  = xp;
    win_l_next.x_end    = xp + w_u;
    win_l_next.y_start  = yp;
    win_l_next.y_end    = yp + h_u;
    win_l_next.col_base = {1'b0, xo} - {1'b0, xp};
    win_l_next.row_base = {1'b0, yo} - {1'b0, yp};
    win_l_next.stride   = sw;

    win_c_next.x_start  = xp >> 1;
    win_c_next.x_end    = (xp >> 1) + (w_u >> 1);
    win_c_next.y_start  = yp >> 1;
    win_c_next.y_end    = (yp >> 1) + (h_u >> 1);
    win_c_next.col_base = {1'b0, xo >> 1} - {1'b0, xp >> 1};
    win_c_next.row_base = {1'b0, yo >> 1} - {1'b0, yp >> 1};
    win_c_next.stride   = sw >> 1;

    alpha_sat_next = (alpha_q8 > pyob_pkg::ALPHA_ONE) ? pyob_pkg::ALPHA_ONE : alpha_q8;
  end

  always_ff @(posedge clk) begin
    win_l     <= win_l_next;
    win_c     <= win_c_next;
    win_ok    <= win_ok_next;
    alpha_sat <= alpha_sat_next;
  end

  // scan position: settle onto a byte that exists, then step past it
  logic [1:0]       pn, nxt_plane;
  logic [POS_W-1:0] rn, cn;
  logic             ok_cur, more_planes, last;
  logic [DIM_W-1:0] pw_s, ph_s, pw_n, ph_n;
  logic [DIM_W-1:0] r_inc, c_inc, r_inc2;

  always_comb begin
    ok_cur = (plane_index == pyob_pkg::PLANE_Y) ? ok_y : ok_c;
    pw_s = (plane_index == pyob_pkg::PLANE_Y) ? fw : (fw >> 1);
    ph_s = (plane_index == pyob_pkg::PLANE_Y) ? fh : (fh >> 1);
    if (plane_index == pyob_pkg::PLANE_Y && ok_c) nxt_plane = pyob_pkg::PLANE_U;
    else if (plane_index == pyob_pkg::PLANE_U && ok_c) nxt_plane = pyob_pkg::PLANE_V;
    else nxt_plane = pyob_pkg::PLANE_Y;
    r_inc = DIM_W'(row_count) + DIM_W'(1);

    pn = plane_index;
    rn = row_count;
    cn = col_count;
    if (plane_index == pyob_pkg::PLANE_NONE) begin
      pn = pyob_pkg::PLANE_Y;
      rn = '0;
      cn = '0;
    end else if (!ok_cur || DIM_W'(row_count) >= ph_s) begin
      pn = nxt_plane;
      rn = '0;
      cn = '0;
    end else if (DIM_W'(col_count) >= pw_s) begin
      cn = '0;
      if (r_inc >= ph_s) begin
        pn = nxt_plane;
        rn = '0;
      end else begin
        rn = r_inc[POS_W-1:0];
      end
    end

    pw_n = (pn == pyob_pkg::PLANE_Y) ? fw : (fw >> 1);
    ph_n = (pn == pyob_pkg::PLANE_Y) ? fh : (fh >> 1);
    more_planes = (pn == pyob_pkg::PLANE_Y || pn == pyob_pkg::PLANE_U) && ok_c;
    c_inc  = DIM_W'(cn) + DIM_W'(1);
    r_inc2 = DIM_W'(rn) + DIM_W'(1);

    plane_index_next = pn;
    row_count_next   = rn;
    col_count_next   = c_inc[POS_W-1:0];
    last             = 1'b0;
    if (c_inc >= pw_n) begin
      col_count_next = '0;
      if (r_inc2 >= ph_n) begin
        row_count_next   = '0;
        last             = !more_planes;
        plane_index_next = last ? pyob_pkg::PLANE_Y : pn + 2'd1;
      end else begin
        row_count_next = r_inc2[POS_W-1:0];
      end
    end

    // empty frame: the settling pass spins through the plane codes
    if (frame_empty) begin
      row_count_next = '0;
      col_count_next = '0;
      last           = 1'b1;
      case (plane_index)
        pyob_pkg::PLANE_Y: plane_index_next = pyob_pkg::PLANE_V;
        pyob_pkg::PLANE_U: plane_index_next = pyob_pkg::PLANE_NONE;
        pyob_pkg::PLANE_V: plane_index_next = pyob_pkg::PLANE_U;
        default:           plane_index_next = pyob_pkg::PLANE_V;
      endcase
    end
  end

  // handshake
  assign advance   = !res_valid || res_ready;
  assign pix_ready = !a_valid || advance;
  assign pix_fire  = pix_valid && pix_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_index <= pyob_pkg::PLANE_Y;
      row_count   <= '0;
      col_count   <= '0;
      a_valid     <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      if (pix_fire) begin
        plane_index <= plane_index_next;
        row_count   <= row_count_next;
        col_count   <= col_count_next;
      end
      if (pix_ready) begin
        a_valid <= pix_valid;
      end
      if (advance) begin
        res_valid <= a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pix_fire) begin
      a_item  <= pix_data;
      a_plane <= frame_empty ? pyob_pkg::PLANE_Y : pn;
      a_row   <= rn;
      a_col   <= cn;
      a_last  <= last;
      a_empty <= frame_empty;
    end
  end

  // stage b: coverage, source offset and blend
  pyob_pkg::win_t      win;
  pyob_pkg::res_item_t res_next;
  logic [DIM_W-1:0]    r_pos, c_pos, row_trunc, col_trunc;
  logic [DIM_W:0]      row_term, col_term;
  logic [2*DIM_W-1:0]  ofs_prod;
  logic [OFS_W-1:0]    ofs_sum;
  logic                cov;
  logic [15:0]         diff, blend_prod, blend_sum;

  always_comb begin
    win   = (a_plane == pyob_pkg::PLANE_Y) ? win_l : win_c;
    r_pos = DIM_W'(a_row);
    c_pos = DIM_W'(a_col);
    cov = !a_empty && win_ok &&
          (r_pos >= win.y_start) && (r_pos < win.y_end) &&
          (c_pos >= win.x_start) && (c_pos < win.x_end);

    row_term  = {1'b0, r_pos} + win.row_base;
    col_term  = {1'b0, c_pos} + win.col_base;
    row_trunc = row_term[DIM_W-1:0];
    col_trunc = col_term[DIM_W-1:0];
    ofs_prod  = row_trunc * win.stride;
    ofs_sum   = ofs_prod[OFS_W-1:0] + OFS_W'(col_trunc);

    // all modulo 2^16, as the blend is defined
    diff       = {8'b0, a_item.src_byte} - {8'b0, a_item.dest_byte};
    blend_prod = diff * 16'(alpha_sat);
    blend_sum  = {a_item.dest_byte, 8'b0} + blend_prod;

    res_next.out_byte   = cov ? blend_sum[15:8] : a_item.dest_byte;
    res_next.covered    = cov;
    res_next.src_offset = cov ? ofs_sum : '0;
    res_next.plane_id   = a_plane;
    res_next.frame_end  = a_last;
  end

  always_ff @(posedge clk) begin
    if (advance && a_valid) begin
      res_data <= res_next;
    end
  end

`ifndef SYNTHESIS
  a_offset_zero_uncovered: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_data.covered |-> res_data.src_offset == '0)
    else $error("source offset set on an uncovered byte");

  a_plane_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_data.plane_id != pyob_pkg::PLANE_NONE)
    else $error("result carries an unused plane code");

  a_skid_accepts: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready && !a_valid |-> pix_ready)
    else $error("input stage empty but no beat taken while output stalls");

  a_empty_frame_end: assert property (@(posedge clk) disable iff (rst)
    pix_fire && frame_empty |=> a_last && a_plane == pyob_pkg::PLANE_Y)
    else $error("empty frame beat not marked as frame end");
`endif

endmodule

// File: verif/tb_planar_yuv_overlay_blend_top.sv
// ----------------------------------------------------------------------------
// tb_planar_yuv_overlay_blend_top
// Drives destination/source byte pairs through the 4:2:0 overlay blender
// under random source gaps and sink stalls. A cycle-free model of the
// raster scan, window clipping and alpha mix predicts every result beat,
// which is checked field by field in order. Registers are rewritten
// between phases, covering empty, clipped, saturated and shrunk frames.
// ----------------------------------------------------------------------------
module tb_planar_yuv_overlay_blend_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IW      = pyob_pkg::CFG_IDX_W;
  localparam int CW      = pyob_pkg::CFG_DATA_W;
  localparam int AW      = pyob_pkg::ALPHA_W;
  localparam int OFS_W   = pyob_pkg::OFS_W;
  localparam int MAX_DIM = pyob_pkg::MAX_DIM;

  localparam logic [IW-1:0] REG_SPARE = 3'd7;
  localparam int RANDOM_ITEMS = 1900;
  localparam int DRAIN_CYCLES = 6;
  localparam int STALL_LIMIT  = 2000;
  localparam int PRINT_LIMIT  = 50;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  pix_valid = 1'b0;
  logic                  pix_ready;
  pyob_pkg::pix_item_t   pix_data = '0;
  logic                  res_valid;
  logic                  res_ready = 1'b0;
  pyob_pkg::res_item_t   res_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [IW-1:0]         cfg_index = '0;
  logic [CW-1:0]         cfg_data = '0;

  // register shadow, reset values
  logic [CW-1:0] ov_x = '0, ov_y = '0, src_w = '0, src_h = '0;
  logic [CW-1:0] frm_w = '0, frm_h = '0;
  logic [AW-1:0] alpha_reg = pyob_pkg::ALPHA_ONE;

  // scan position of the model
  logic [1:0] scan_plane = pyob_pkg::PLANE_Y;
  int         scan_row = 0;
  int         scan_col = 0;

  pyob_pkg::res_item_t expected_blend_q[$];
  int        err_count = 0;
  int        res_seen = 0;
  int        quiet_cycles = 0;
  bit        gaps_on = 1'b1;
  int        sink_hold = 0;

  planar_yuv_overlay_blend_top u_top (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix_data  (pix_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------- model

  function automatic int clamp_dim(logic [CW-1:0] v);
    return (v > MAX_DIM) ? MAX_DIM : int'(v);
  endfunction

  function automatic void plane_size(logic [1:0] p, output int pw, output int ph);
    pw = clamp_dim(frm_w);
    ph = clamp_dim(frm_h);
    if (p != pyob_pkg::PLANE_Y) begin
      pw = pw >>> 1;
      ph = ph >>> 1;
    end
  endfunction

  function automatic bit plane_present(logic [1:0] p);
    int pw, ph;
    if (p > pyob_pkg::PLANE_V) return 1'b0;
    plane_size(p, pw, ph);
    return (pw > 0) && (ph > 0);
  endfunction

  // moves the scan onto an existing byte, 0 when the frame is empty
  function automatic bit seek_scan();
    int pw, ph, k;
    for (k = 0; k < 8; k++) begin
      if (scan_plane > pyob_pkg::PLANE_V) begin
        scan_plane = pyob_pkg::PLANE_Y;
        scan_row = 0;
        scan_col = 0;
      end
      plane_size(scan_plane, pw, ph);
      if (!plane_present(scan_plane) || scan_row >= ph) begin
        scan_plane = scan_plane + 2'd1;
        scan_row = 0;
        scan_col = 0;
      end else if (scan_col >= pw) begin
        scan_col = 0;
        scan_row++;
      end else begin
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic pyob_pkg::res_item_t predict_blend(pyob_pkg::pix_item_t pix);
    pyob_pkg::res_item_t r;
    int sw, sh, fw, fh, xp, yp, xo, yo, w, h, stride, pw, ph, ofs, k;
    bit win_ok;
    logic [31:0] diff, prod;
    logic [15:0] mix;
    logic [AW-1:0] a;
    r = '0;
    r.out_byte = pix.dest_byte;
    if (!seek_scan()) begin
      r.frame_end = 1'b1;
      return r;
    end
    sw = clamp_dim(src_w);
    sh = clamp_dim(src_h);
    fw = clamp_dim(frm_w);
    fh = clamp_dim(frm_h);
    xp = $signed(ov_x);
    yp = $signed(ov_y);
    if (xp % 2 != 0) xp++;
    if (yp % 2 != 0) yp++;
    xo = 0;
    yo = 0;
    win_ok = 1'b1;
    if (xp < 0) begin
      xo = -xp;
      xp = 0;
    end
    if (yp < 0) begin
      yo = -yp;
      yp = 0;
    end
    if (xo > sw || yo > sh) win_ok = 1'b0;
    w = (fw - xp < sw - xo) ? fw - xp : sw - xo;
    h = (fh - yp < sh - yo) ? fh - yp : sh - yo;
    if (w < 0 || h < 0) win_ok = 1'b0;
    stride = sw;
    if (scan_plane != pyob_pkg::PLANE_Y) begin
      w = w >>> 1;
      h = h >>> 1;
      xp = xp >>> 1;
      yp = yp >>> 1;
      xo = xo >>> 1;
      yo = yo >>> 1;
      stride = sw >>> 1;
    end
    if (win_ok && scan_row >= yp && scan_row < yp + h &&
        scan_col >= xp && scan_col < xp + w) begin
      r.covered = 1'b1;
      ofs = (yo + scan_row - yp) * stride + (xo + scan_col - xp);
      r.src_offset = ofs[OFS_W-1:0];
      a = (alpha_reg > pyob_pkg::ALPHA_ONE) ? pyob_pkg::ALPHA_ONE : alpha_reg;
      // unsigned wrap of the difference is intended, only the low 16 bits count
      diff = {24'd0, pix.src_byte} - {24'd0, pix.dest_byte};
      prod = diff * {23'd0, a};
      mix = {pix.dest_byte, 8'd0} + prod[15:0];
      r.out_byte = mix[15:8];
    end
    r.plane_id = scan_plane;

    plane_size(scan_plane, pw, ph);
    scan_col++;
    if (scan_col >= pw) begin
      scan_col = 0;
      scan_row++;
      if (scan_row >= ph) begin
        r.frame_end = 1'b1;
        for (k = int'(scan_plane) + 1; k <= int'(pyob_pkg::PLANE_V); k++)
          if (plane_present(k[1:0])) r.frame_end = 1'b0;
        scan_row = 0;
        scan_plane = r.frame_end ? pyob_pkg::PLANE_Y : scan_plane + 2'd1;
      end
    end
    return r;
  endfunction

  function automatic void apply_reg(logic [IW-1:0] idx, logic [CW-1:0] val);
    case (idx)
      pyob_pkg::REG_OVERLAY_X:     ov_x = val;
      pyob_pkg::REG_OVERLAY_Y:     ov_y = val;
      pyob_pkg::REG_SOURCE_WIDTH:  src_w = val;
      pyob_pkg::REG_SOURCE_HEIGHT: src_h = val;
      pyob_pkg::REG_FRAME_WIDTH:   frm_w = val;
      pyob_pkg::REG_FRAME_HEIGHT:  frm_h = val;
      pyob_pkg::REG_ALPHA_Q8:      alpha_reg = val[AW-1:0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------- drivers

  // mostly back-to-back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  task automatic send_pix(input logic [7:0] dest, input logic [7:0] src);
    int g;
    g = pick_gap();
    if (g != 0) begin
      pix_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    pix_valid <= 1'b1;
    pix_data <= '{dest_byte: dest, src_byte: src};
    do @(posedge clk); while (!pix_ready);
    expected_blend_q.push_back(predict_blend(pix_data));
  endtask

  // valid stays high across back-to-back writes, the caller drops it
  task automatic write_reg(input logic [IW-1:0] idx, input logic [CW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, val);
  endtask

  task automatic program_overlay(input logic [CW-1:0] ox, input logic [CW-1:0] oy,
                                 input logic [CW-1:0] sw, input logic [CW-1:0] sh,
                                 input logic [CW-1:0] fw, input logic [CW-1:0] fh,
                                 input logic [CW-1:0] al, input bit poke_spare);
    write_reg(pyob_pkg::REG_OVERLAY_X, ox);
    write_reg(pyob_pkg::REG_OVERLAY_Y, oy);
    write_reg(pyob_pkg::REG_SOURCE_WIDTH, sw);
    write_reg(pyob_pkg::REG_SOURCE_HEIGHT, sh);
    write_reg(pyob_pkg::REG_FRAME_WIDTH, fw);
    write_reg(pyob_pkg::REG_FRAME_HEIGHT, fh);
    write_reg(pyob_pkg::REG_ALPHA_Q8, al);
    if (poke_spare) write_reg(REG_SPARE, CW'($urandom_range(0, 8191)));
    cfg_valid <= 1'b0;
  endtask

  task automatic drain_results();
    pix_valid <= 1'b0;
    while (expected_blend_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- sink and checks

  always @(posedge clk) begin : sink_ctl
    int g;
    if (sink_hold != 0) begin
      sink_hold <= sink_hold - 1;
      res_ready <= 1'b0;
    end else begin
      g = pick_gap();
      sink_hold <= g;
      res_ready <= (g == 0);
    end
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    err_count++;
    if (err_count <= PRINT_LIMIT)
      $display("result %0d: %s is 0x%0h, 0x%0h predicted", res_seen, what, got, want);
  endtask

  always @(posedge clk) begin : check_results
    pyob_pkg::res_item_t want;
    if (!rst && res_valid && res_ready) begin
      if (expected_blend_q.size() == 0) begin
        report_mismatch("beat with nothing pending, out_byte", res_data.out_byte, 0);
      end else begin
        want = expected_blend_q.pop_front();
        if (res_data.out_byte !== want.out_byte)
          report_mismatch("out_byte", res_data.out_byte, want.out_byte);
        if (res_data.covered !== want.covered)
          report_mismatch("covered", res_data.covered, want.covered);
        if (res_data.src_offset !== want.src_offset)
          report_mismatch("src_offset", res_data.src_offset, want.src_offset);
        if (res_data.plane_id !== want.plane_id)
          report_mismatch("plane_id", res_data.plane_id, want.plane_id);
        if (res_data.frame_end !== want.frame_end)
          report_mismatch("frame_end", res_data.frame_end, want.frame_end);
      end
      res_seen++;
    end
  end

  always @(posedge clk) begin
    if ((pix_valid && pix_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- tests

  // register defaults give an empty frame, every byte passes with frame_end
  task automatic test_empty_frame();
    send_pix(8'hff, 8'h00);
    send_pix(8'h00, 8'hff);
  endtask

  // odd x rounds up, negative y clips into the source, chroma halves it all
  task automatic test_window_corners();
    drain_results();
    program_overlay(13'd1, -13'sd3, 13'd4, 13'd4, 13'd4, 13'd2, 13'd256, 1'b1);
    send_pix(8'h00, 8'hff);
    send_pix(8'hff, 8'h00);
    send_pix(8'hff, 8'hff);
    send_pix(8'h00, 8'h00);
    send_pix(8'h80, 8'h7f);
    repeat (7) send_pix(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  task automatic test_alpha_limits();
    drain_results();
    program_overlay(13'd0, 13'd0, 13'd4, 13'd4, 13'd4, 13'd2, 13'd0, 1'b0);
    send_pix(8'h5a, 8'ha5);
    drain_results();
    // upper data bits ignored, 511 saturates to a plain copy
    program_overlay(13'd0, 13'd0, 13'd4, 13'd4, 13'd4, 13'd2, 13'h1fff, 1'b0);
    send_pix(8'h5a, 8'ha5);
    drain_results();
    program_overlay(13'd0, 13'd0, 13'd4, 13'd4, 13'd4, 13'd2, 13'd128, 1'b0);
    send_pix(8'h01, 8'hfe);
  endtask

  task automatic test_window_outside();
    drain_results();
    // clipped part wider than the source
    program_overlay(13'h1000, 13'h0fff, 13'd4, 13'd4, 13'd4, 13'd2, 13'd256, 1'b0);
    send_pix(8'h12, 8'h34);
    drain_results();
    // window starts past the right edge
    program_overlay(13'd6, 13'd0, 13'd4, 13'd4, 13'd4, 13'd2, 13'd256, 1'b0);
    send_pix(8'h56, 8'h78);
  endtask

  task automatic test_saturated_and_shrunk();
    drain_results();
    program_overlay(13'd0, 13'd0, 13'h1fff, 13'h1fff, 13'h1fff, 13'h1fff, 13'd200, 1'b0);
    repeat (3) send_pix(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    drain_results();
    // scan lands past the new width; chroma planes vanish at width one
    program_overlay(13'd0, 13'd0, 13'd8, 13'd8, 13'd1, 13'd3, 13'd64, 1'b0);
    repeat (2) send_pix(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  function automatic logic [CW-1:0] pick_dim(int maxv);
    int r;
    r = $urandom_range(0, 99);
    if (r < 84) return CW'($urandom_range(0, maxv));
    if (r < 89) return CW'(MAX_DIM);
    if (r < 95) return CW'($urandom_range(MAX_DIM + 1, 8191));
    return CW'($urandom_range(0, 8191));
  endfunction

  function automatic logic [CW-1:0] pick_pos();
    int v;
    if ($urandom_range(0, 99) < 80) begin
      v = int'($urandom_range(0, 26)) - 8;
      return v[CW-1:0];
    end
    return CW'($urandom_range(0, 8191));
  endfunction

  function automatic logic [CW-1:0] pick_alpha();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return '0;
    if (r < 25) return CW'(pyob_pkg::ALPHA_ONE);
    if (r < 37) return CW'($urandom_range(257, 511));
    if (r < 47) return CW'($urandom_range(0, 8191));
    return CW'($urandom_range(0, 255));
  endfunction

  task automatic test_random_overlays();
    int sent, n, fw, fh, total;
    logic [CW-1:0] fwv, fhv;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      fwv = pick_dim(16);
      fhv = pick_dim(10);
      drain_results();
      gaps_on = ($urandom_range(0, 3) != 0);
      program_overlay(pick_pos(), pick_pos(), pick_dim(20), pick_dim(14), fwv, fhv,
                      pick_alpha(), $urandom_range(0, 19) == 0);
      fw = clamp_dim(fwv);
      fh = clamp_dim(fhv);
      total = fw * fh + 2 * (fw / 2) * (fh / 2);
      // whole frames where they are small, otherwise a slice of the scan
      if (total == 0 || total > 150 || $urandom_range(0, 4) == 0)
        n = $urandom_range(1, 40);
      else
        n = total + $urandom_range(0, total / 2);
      repeat (n) send_pix(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      sent += n;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_frame();
    test_window_corners();
    test_alpha_limits();
    test_window_outside();
    test_saturated_and_shrunk();
    test_random_overlays();
    drain_results();
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
